>>> hdl/rc_pulse_width_decoder_macros.svh
// ----------------------------------------------------------------------------
// RC pulse width decoder assertion macros
// Concurrent check wrappers that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef RC_PULSE_WIDTH_DECODER_MACROS_SVH
`define RC_PULSE_WIDTH_DECODER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted
`define RCPWD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RCPWD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define RCPWD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define RCPWD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> hdl/rcpwd_pkg.sv
// ----------------------------------------------------------------------------
// RC pulse width decoder package
// Shared types, register indexes, reset values and arithmetic constants.
// ----------------------------------------------------------------------------
package rcpwd_pkg;

	// Fine timer period is 2^FINE_PERIOD_BITS counts
	localparam int FINE_PERIOD_BITS = 9;
	localparam logic [15:0] FINE_PERIOD = 16'(1 << FINE_PERIOD_BITS);
	localparam logic [15:0] FINE_MASK   = 16'((1 << FINE_PERIOD_BITS) - 1);

	// Divide by 3 as multiply by ceil(2^17 / 3), exact for 16-bit operands
	localparam int          DIV3_SHIFT = 17;
	localparam logic [16:0] DIV3_RECIP = 17'd43691;

	localparam logic [7:0] COUNT_MAX = 8'd255;

	// Request codes
	typedef enum logic [1:0] {
		REQ_OVERFLOW = 2'd0,
		REQ_COARSE   = 2'd1,
		REQ_CAPTURE  = 2'd2
	} req_type_t;

	// Register indexes
	localparam logic [1:0] CFG_MATCH_WINDOW = 2'd0;
	localparam logic [1:0] CFG_ZERO_OFFSET  = 2'd1;
	localparam logic [1:0] CFG_VALID_LOW    = 2'd2;
	localparam logic [1:0] CFG_VALID_SPAN   = 2'd3;

	// Register reset values
	localparam logic [11:0] MATCH_WINDOW_RST = 12'd300;
	localparam logic [15:0] ZERO_OFFSET_RST  = 16'd3100;
	localparam logic [15:0] VALID_LOW_RST    = 16'd2701;
	localparam logic [15:0] VALID_SPAN_RST   = 16'd499;

	typedef struct packed {
		logic [11:0] match_window;
		logic [15:0] zero_offset;
		logic [15:0] valid_low;
		logic [15:0] valid_span;
	} rcpwd_cfg_t;

	// Measurement state seen by the width unit
	typedef struct packed {
		logic [7:0] overflow_count;
		logic [7:0] start_overflow;
		logic [8:0] start_time;
		logic [7:0] coarse_count;
	} rcpwd_meas_t;

endpackage

>>> hdl/rcpwd_cfg.sv
// ----------------------------------------------------------------------------
// RC pulse width decoder configuration registers
// Write-only register file holding window, offset and valid range settings.
// ----------------------------------------------------------------------------
module rcpwd_cfg
	import rcpwd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output rcpwd_cfg_t  cfg
);

	rcpwd_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.match_window <= MATCH_WINDOW_RST;
			cfg_q.zero_offset  <= ZERO_OFFSET_RST;
			cfg_q.valid_low    <= VALID_LOW_RST;
			cfg_q.valid_span   <= VALID_SPAN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MATCH_WINDOW: cfg_q.match_window <= cfg_data[11:0];
				CFG_ZERO_OFFSET:  cfg_q.zero_offset  <= cfg_data;
				CFG_VALID_LOW:    cfg_q.valid_low    <= cfg_data;
				CFG_VALID_SPAN:   cfg_q.valid_span   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> hdl/rcpwd_width.sv
// ----------------------------------------------------------------------------
// RC pulse width decoder width unit
// Forms the raw width, corrects it against the coarse count, divides by 3.
// ----------------------------------------------------------------------------
module rcpwd_width
	import rcpwd_pkg::*;
(
	input  rcpwd_meas_t  meas,
	input  logic [8:0]   capture_time,
	input  logic [11:0]  match_window,
	output logic [14:0]  width_div3
);

	logic [15:0] cap;
	logic [15:0] delta_w;
	logic [15:0] w0;
	logic [15:0] coarse;
	logic [15:0] hi;
	logic [15:0] lo;
	logic [15:0] wm1, wm2, wp1, wp2;
	logic        a0, a1, a2, b0, b1, b2;
	logic [15:0] w_fix;
	logic [32:0] prod;

	always_comb begin
		cap     = {7'd0, capture_time} & FINE_MASK;
		delta_w = 16'({8'd0, 8'(meas.overflow_count - meas.start_overflow)} << FINE_PERIOD_BITS);
		w0      = delta_w + cap - {7'd0, meas.start_time};
		coarse  = {2'd0, meas.coarse_count, 6'd0};
		hi      = coarse + {4'd0, match_window};
		lo      = coarse - {4'd0, match_window};

		// All correction candidates in parallel, then pick
		wm1 = w0 - FINE_PERIOD;
		wm2 = w0 - {FINE_PERIOD[14:0], 1'b0};
		wp1 = w0 + FINE_PERIOD;
		wp2 = w0 + {FINE_PERIOD[14:0], 1'b0};
		a0  = hi < w0;
		a1  = hi < wm1;
		a2  = hi < wm2;
		b0  = lo > w0;
		b1  = lo > wp1;
		b2  = lo > wp2;

		if (a0) begin
			if (!a1)      w_fix = wm1;
			else if (!a2) w_fix = wm2;
			else          w_fix = coarse;
		end else if (b0) begin
			if (!b1)      w_fix = wp1;
			else if (!b2) w_fix = wp2;
			else          w_fix = coarse;
		end else begin
			w_fix = w0;
		end

		prod       = {17'd0, w_fix} * {16'd0, DIV3_RECIP};
		width_div3 = prod[DIV3_SHIFT +: 15];
	end

endmodule

>>> hdl/rcpwd_filter.sv
// ----------------------------------------------------------------------------
// RC pulse width decoder filter
// Counts in-range widths, removes the offset and applies the 3/4 IIR filter.
// ----------------------------------------------------------------------------
module rcpwd_filter
	import rcpwd_pkg::*;
(
	input  logic [14:0] width_div3,
	input  rcpwd_cfg_t  cfg,
	input  logic [7:0]  good_count,
	input  logic [13:0] filtered_value,
	output logic [7:0]  good_count_nxt,
	output logic [13:0] filtered_nxt
);

	logic [15:0] w;
	logic [15:0] rel;
	logic [15:0] clamped;
	logic [15:0] x;
	logic [15:0] sum;

	always_comb begin
		w   = {1'b0, width_div3};
		rel = w - cfg.valid_low;
		if (good_count != COUNT_MAX && rel < cfg.valid_span) begin
			good_count_nxt = good_count + 8'd1;
		end else begin
			good_count_nxt = good_count;
		end

		clamped      = (w < cfg.zero_offset) ? cfg.zero_offset : w;
		x            = clamped - cfg.zero_offset;
		// 3*f + x, wrapping at 16 bits
		sum          = {1'b0, filtered_value, 1'b0} + {2'd0, filtered_value} + x;
		filtered_nxt = sum[15:2];
	end

endmodule

>>> hdl/rc_pulse_width_decoder.sv
// ----------------------------------------------------------------------------
// RC pulse width decoder
// Measures RC servo pulse widths from timer events and filters the command.
// ----------------------------------------------------------------------------
// Each input word is an event: a fine timer overflow tick, a coarse 8 us tick
// or a capture edge with a 9-bit timestamp. Capture edges alternate between
// rising and falling. A falling edge produces a new width, corrected against
// the coarse count, divided by 3, checked against the valid range and passed
// through the 3/4 IIR filter after offset removal. Every input word yields
// exactly one output word carrying the current filtered value, the saturating
// valid count and a flag for a fresh value. The block takes one word per
// clock unless the result register stalls: each word is held in the input
// register while the width and filter logic updates the state and loads the
// result register. A stalled result register holds the input register,
// which then raises in_stall. Configuration writes take effect on the next
// clock; there is no read-back.
// ----------------------------------------------------------------------------
`include "rc_pulse_width_decoder_macros.svh"

module rc_pulse_width_decoder
	import rcpwd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [8:0]  capture_time,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [13:0] pulse_value,
	output logic [7:0]  valid_count,
	output logic        new_value,

	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	rcpwd_cfg_t  cfg;

	// Input register
	logic        valid_s1;
	logic [1:0]  type_s1;
	logic [8:0]  cap_s1;

	// Decoder state
	logic [7:0]  overflow_count_q;
	logic [7:0]  start_overflow_q;
	logic [8:0]  start_time_q;
	logic        expect_falling_q;
	logic [7:0]  coarse_count_q;
	logic [13:0] filtered_q;
	logic [7:0]  good_count_q;

	// Result register
	logic        out_valid_q;
	logic [13:0] pulse_value_q;
	logic [7:0]  valid_count_q;
	logic        new_value_q;

	logic        fire_s1;
	logic        is_capture;
	logic        falling;
	rcpwd_meas_t meas;
	logic [14:0] width_div3;
	logic [7:0]  good_count_nxt;
	logic [13:0] filtered_nxt;

	rcpwd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Advance the input stage unless a finished word is still waiting
	assign fire_s1    = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall   = valid_s1 && out_valid_q && out_stall;
	assign is_capture = (type_s1 == REQ_CAPTURE);
	assign falling    = is_capture && expect_falling_q;

	assign meas.overflow_count = overflow_count_q;
	assign meas.start_overflow = start_overflow_q;
	assign meas.start_time     = start_time_q;
	assign meas.coarse_count   = coarse_count_q;

	rcpwd_width u_width (
		.meas         (meas),
		.capture_time (cap_s1),
		.match_window (cfg.match_window),
		.width_div3   (width_div3)
	);

	rcpwd_filter u_filter (
		.width_div3     (width_div3),
		.cfg            (cfg),
		.good_count     (good_count_q),
		.filtered_value (filtered_q),
		.good_count_nxt (good_count_nxt),
		.filtered_nxt   (filtered_nxt)
	);

	// Input register: load whenever it is free or draining this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			type_s1 <= req_type;
			cap_s1  <= capture_time;
		end
	end

	// State update, one event per advancing word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			overflow_count_q <= '0;
			start_overflow_q <= '0;
			start_time_q     <= '0;
			expect_falling_q <= 1'b0;
			coarse_count_q   <= '0;
			filtered_q       <= '0;
			good_count_q     <= '0;
		end else if (fire_s1) begin
			case (type_s1)
				REQ_OVERFLOW: begin
					overflow_count_q <= overflow_count_q + 8'd1;
				end
				REQ_COARSE: begin
					coarse_count_q <= coarse_count_q + 8'd1;
				end
				REQ_CAPTURE: begin
					if (!expect_falling_q) begin
						// Rising edge: mark the start of the pulse
						start_overflow_q <= overflow_count_q;
						start_time_q     <= 9'(({7'd0, cap_s1} & FINE_MASK));
						coarse_count_q   <= '0;
						expect_falling_q <= 1'b1;
					end else begin
						// Falling edge: commit the new measurement
						expect_falling_q <= 1'b0;
						good_count_q     <= good_count_nxt;
						filtered_q       <= filtered_nxt;
					end
				end
				default: ;
			endcase
		end
	end

	// Result register: drop the word once taken, load a new one on advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			pulse_value_q <= falling ? filtered_nxt : filtered_q;
			valid_count_q <= falling ? good_count_nxt : good_count_q;
			new_value_q   <= falling;
		end
	end

	assign out_valid   = out_valid_q;
	assign pulse_value = pulse_value_q;
	assign valid_count = valid_count_q;
	assign new_value   = new_value_q;

	// Stall only when a word waits in the input register
	`RCPWD_ASSERT_IMPLY(a_stall_needs_word, clk, arst_n, in_stall, valid_s1 && out_valid_q, "input stall without a waiting word")

	// Every capture edge flips the edge expectation
	`RCPWD_ASSERT_NEXT(a_edge_toggle, clk, arst_n, fire_s1 && is_capture, expect_falling_q != $past(expect_falling_q), "capture edge did not toggle edge state")

	// The valid count never moves backward
	`RCPWD_ASSERT_NEXT(a_count_mono, clk, arst_n, 1'b1, good_count_q >= $past(good_count_q), "valid count decreased")

endmodule
